>>> rtl/s2a_pkg.sv
// Shared types, codes and translation tables for the scancode-to-ASCII key queue.
package s2a_pkg;

    // Field widths fixed by the item formats.
    localparam int unsigned OP_W    = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LIMIT_W = 7;

    // Operation codes carried in the op field.
    localparam logic [OP_W-1:0] OP_KEY   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    // Controller status bits.
    localparam int unsigned STAT_OBF_BIT = 0;
    localparam int unsigned STAT_AUX_BIT = 5;

    // Set-1 scancodes for the shift keys and the release marker.
    localparam logic [BYTE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [BYTE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [BYTE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [BYTE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam int unsigned       SC_BREAK_BIT    = 7;

    // Depth of the command queue between the front and the back.
    localparam int unsigned CMDQ_DEPTH = 2;
    localparam int unsigned CMDQ_IW    = $clog2(CMDQ_DEPTH);
    localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    // One input item.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [BYTE_W-1:0]  ctrl_status;
        logic [BYTE_W-1:0]  scan_byte;
        logic [LIMIT_W-1:0] read_limit;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0]  char_byte;
        logic               key_queued;
        logic               byte_valid;
        logic [LIMIT_W-1:0] bytes_popped;
        logic               last_result;
    } t_out_item;

    // Classified work handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_KEY   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [BYTE_W-1:0]  ch;
        logic [LIMIT_W-1:0] limit;
    } t_cmd;

    // US layout, no shift.
    function automatic logic [BYTE_W-1:0] f_plain(input logic [6:0] code);
        logic [BYTE_W-1:0] ch;
        case (code)
            7'd1:    ch = 8'h1B;
            7'd2:    ch = 8'h31;
            7'd3:    ch = 8'h32;
            7'd4:    ch = 8'h33;
            7'd5:    ch = 8'h34;
            7'd6:    ch = 8'h35;
            7'd7:    ch = 8'h36;
            7'd8:    ch = 8'h37;
            7'd9:    ch = 8'h38;
            7'd10:   ch = 8'h39;
            7'd11:   ch = 8'h30;
            7'd12:   ch = 8'h2D;
            7'd13:   ch = 8'h3D;
            7'd14:   ch = 8'h08;
            7'd15:   ch = 8'h09;
            7'd16:   ch = 8'h71;
            7'd17:   ch = 8'h77;
            7'd18:   ch = 8'h65;
            7'd19:   ch = 8'h72;
            7'd20:   ch = 8'h74;
            7'd21:   ch = 8'h79;
            7'd22:   ch = 8'h75;
            7'd23:   ch = 8'h69;
            7'd24:   ch = 8'h6F;
            7'd25:   ch = 8'h70;
            7'd26:   ch = 8'h5B;
            7'd27:   ch = 8'h5D;
            7'd28:   ch = 8'h0A;
            7'd30:   ch = 8'h61;
            7'd31:   ch = 8'h73;
            7'd32:   ch = 8'h64;
            7'd33:   ch = 8'h66;
            7'd34:   ch = 8'h67;
            7'd35:   ch = 8'h68;
            7'd36:   ch = 8'h6A;
            7'd37:   ch = 8'h6B;
            7'd38:   ch = 8'h6C;
            7'd39:   ch = 8'h3B;
            7'd40:   ch = 8'h27;
            7'd41:   ch = 8'h60;
            7'd43:   ch = 8'h5C;
            7'd44:   ch = 8'h7A;
            7'd45:   ch = 8'h78;
            7'd46:   ch = 8'h63;
            7'd47:   ch = 8'h76;
            7'd48:   ch = 8'h62;
            7'd49:   ch = 8'h6E;
            7'd50:   ch = 8'h6D;
            7'd51:   ch = 8'h2C;
            7'd52:   ch = 8'h2E;
            7'd53:   ch = 8'h2F;
            7'd55:   ch = 8'h2A;
            7'd57:   ch = 8'h20;
            7'd74:   ch = 8'h2D;
            7'd78:   ch = 8'h2B;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // US layout with shift held.
    function automatic logic [BYTE_W-1:0] f_shifted(input logic [6:0] code);
        logic [BYTE_W-1:0] ch;
        case (code)
            7'd1:    ch = 8'h1B;
            7'd2:    ch = 8'h21;
            7'd3:    ch = 8'h40;
            7'd4:    ch = 8'h23;
            7'd5:    ch = 8'h24;
            7'd6:    ch = 8'h25;
            7'd7:    ch = 8'h5E;
            7'd8:    ch = 8'h26;
            7'd9:    ch = 8'h2A;
            7'd10:   ch = 8'h28;
            7'd11:   ch = 8'h29;
            7'd12:   ch = 8'h5F;
            7'd13:   ch = 8'h2B;
            7'd14:   ch = 8'h08;
            7'd15:   ch = 8'h09;
            7'd16:   ch = 8'h51;
            7'd17:   ch = 8'h57;
            7'd18:   ch = 8'h45;
            7'd19:   ch = 8'h52;
            7'd20:   ch = 8'h54;
            7'd21:   ch = 8'h59;
            7'd22:   ch = 8'h55;
            7'd23:   ch = 8'h49;
            7'd24:   ch = 8'h4F;
            7'd25:   ch = 8'h50;
            7'd26:   ch = 8'h7B;
            7'd27:   ch = 8'h7D;
            7'd28:   ch = 8'h0A;
            7'd30:   ch = 8'h41;
            7'd31:   ch = 8'h53;
            7'd32:   ch = 8'h44;
            7'd33:   ch = 8'h46;
            7'd34:   ch = 8'h47;
            7'd35:   ch = 8'h48;
            7'd36:   ch = 8'h4A;
            7'd37:   ch = 8'h4B;
            7'd38:   ch = 8'h4C;
            7'd39:   ch = 8'h3A;
            7'd40:   ch = 8'h22;
            7'd41:   ch = 8'h7E;
            7'd43:   ch = 8'h7C;
            7'd44:   ch = 8'h5A;
            7'd45:   ch = 8'h58;
            7'd46:   ch = 8'h43;
            7'd47:   ch = 8'h56;
            7'd48:   ch = 8'h42;
            7'd49:   ch = 8'h4E;
            7'd50:   ch = 8'h4D;
            7'd51:   ch = 8'h3C;
            7'd52:   ch = 8'h3E;
            7'd53:   ch = 8'h3F;
            7'd55:   ch = 8'h2A;
            7'd57:   ch = 8'h20;
            7'd74:   ch = 8'h2D;
            7'd78:   ch = 8'h2B;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/s2a_front.sv
// Front end: accepts items, tracks the shift key and classifies each item into a command.
module s2a_front #(
    parameter int unsigned MAX_READ = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  s2a_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_push,
    output s2a_pkg::t_cmd     o_cmd
);
    import s2a_pkg::*;

    logic              r_shift;
    logic              n_shift;
    logic              guard;
    logic [BYTE_W-1:0] code;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign code    = i_item.scan_byte;
    assign guard   = i_item.ctrl_status[STAT_OBF_BIT] && !i_item.ctrl_status[STAT_AUX_BIT];

    // Classify the item and work out the shift flag it leaves behind.
    always_comb begin
        n_shift     = r_shift;
        o_cmd.kind  = CMD_NOP;
        o_cmd.ch    = '0;
        o_cmd.limit = '0;
        unique case (i_item.op)
            OP_KEY: begin
                o_cmd.kind = CMD_KEY;
                if (guard) begin
                    if (code == SC_LSHIFT_MAKE || code == SC_RSHIFT_MAKE) begin
                        n_shift = 1'b1;
                    end else if (code == SC_LSHIFT_BREAK || code == SC_RSHIFT_BREAK) begin
                        n_shift = 1'b0;
                    end else if (!code[SC_BREAK_BIT]) begin
                        o_cmd.ch = r_shift ? f_shifted(code[6:0]) : f_plain(code[6:0]);
                    end
                end
            end
            OP_READ: begin
                o_cmd.kind  = CMD_READ;
                o_cmd.limit = (i_item.read_limit > LIMIT_W'(MAX_READ)) ?
                              LIMIT_W'(MAX_READ) : i_item.read_limit;
            end
            OP_FLUSH: begin
                o_cmd.kind = CMD_FLUSH;
            end
            default: begin
                o_cmd.kind = CMD_NOP;
            end
        endcase
    end

    // The shift flag changes only when a key item is actually taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
        end else if (o_push) begin
            r_shift <= n_shift;
        end
    end

endmodule

>>> rtl/s2a_cmd_queue.sv
// Short command queue that decouples the front end from the back end.
module s2a_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  s2a_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output s2a_pkg::t_cmd o_cmd
);
    import s2a_pkg::*;

    t_cmd               r_entry [CMDQ_DEPTH];
    logic [CMDQ_IW-1:0] r_wr_idx;
    logic [CMDQ_IW-1:0] r_rd_idx;
    logic [CMDQ_CW-1:0] r_count;
    logic               do_pop;

    assign o_full  = (r_count == CMDQ_CW'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_idx];
    assign do_pop  = i_pop && o_valid;

    function automatic logic [CMDQ_IW-1:0] f_inc(input logic [CMDQ_IW-1:0] idx);
        return (idx == CMDQ_IW'(CMDQ_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_idx] <= i_cmd;
        end
    end

    // Indexes and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_idx <= f_inc(r_wr_idx);
            end
            if (do_pop) begin
                r_rd_idx <= f_inc(r_rd_idx);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/s2a_back.sv
// Back end: character store, ring pointers, read sequencer and the output register.
module s2a_back #(
    parameter int unsigned FIFO_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  s2a_pkg::t_cmd      i_cmd,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output s2a_pkg::t_out_item o_out_item
);
    import s2a_pkg::*;

    localparam int unsigned PW = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [BYTE_W-1:0]  r_store [FIFO_DEPTH];
    logic [BYTE_W-1:0]  r_rd_data;
    logic [PW-1:0]      r_wr_ptr;
    logic [PW-1:0]      n_wr_ptr;
    logic [PW-1:0]      r_rd_ptr;
    logic [PW-1:0]      n_rd_ptr;
    logic [LIMIT_W-1:0] r_limit;
    logic [LIMIT_W-1:0] n_limit;
    logic [LIMIT_W-1:0] r_cnt;
    logic [LIMIT_W-1:0] n_cnt;
    logic [LIMIT_W-1:0] cnt_inc;
    t_out_item          r_out;
    t_out_item          n_out;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               out_free;
    logic               wr_en;
    logic               fifo_empty;
    logic               pop_last;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_free    = !r_out_valid || i_out_ready;
    assign fifo_empty  = (r_wr_ptr == r_rd_ptr);
    assign cnt_inc     = r_cnt + 1'b1;
    assign pop_last    = (cnt_inc == r_limit) || (f_next(r_rd_ptr) == r_wr_ptr);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Command execution and read sequencing.
    always_comb begin
        n_state     = r_state;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_limit     = r_limit;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_q_pop     = 1'b0;
        wr_en       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop     = 1'b1;
                    n_out       = '0;
                    n_out.last_result = 1'b1;
                    n_out_valid = 1'b1;
                    case (i_cmd.kind)
                        CMD_KEY: begin
                            wr_en = (i_cmd.ch != '0) && (f_next(r_wr_ptr) != r_rd_ptr);
                            n_out.char_byte  = i_cmd.ch;
                            n_out.key_queued = wr_en;
                            if (wr_en) begin
                                n_wr_ptr = f_next(r_wr_ptr);
                            end
                        end
                        CMD_READ: begin
                            // Pops start after the load state; an empty or zero-limit read answers at once.
                            if (i_cmd.limit != '0 && !fifo_empty) begin
                                n_out_valid = 1'b0;
                                n_limit     = i_cmd.limit;
                                n_cnt       = '0;
                                n_state     = S_LOAD;
                            end
                        end
                        CMD_FLUSH: begin
                            n_wr_ptr = '0;
                            n_rd_ptr = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.char_byte    = r_rd_data;
                    n_out.key_queued   = 1'b0;
                    n_out.byte_valid   = 1'b1;
                    n_out.bytes_popped = cnt_inc;
                    n_out.last_result  = pop_last;
                    n_cnt              = cnt_inc;
                    n_rd_ptr           = f_next(r_rd_ptr);
                    n_state            = pop_last ? S_IDLE : S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Character store with a registered read port at the read pointer.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_wr_ptr] <= i_cmd.ch;
        end
        r_rd_data <= r_store[r_rd_ptr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_limit <= n_limit;
        r_cnt   <= n_cnt;
    end

`ifndef ASSERT_OFF
    // A stored character always leaves the queue non-empty.
    a_write_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_wr_ptr != r_rd_ptr))
        else $error("character store empty right after a write");

    // A read in progress only ever pops from a non-empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD || r_state == S_EMIT) |-> (r_wr_ptr != r_rd_ptr))
        else $error("read sequencer active on an empty store");

    // The pop count stays below the limit while a read is active.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD || r_state == S_EMIT) |-> (r_cnt < r_limit))
        else $error("read popped past its limit");

    // Pointers never leave the ring.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr <= PW'(FIFO_DEPTH - 1)) && (r_rd_ptr <= PW'(FIFO_DEPTH - 1)))
        else $error("ring pointer out of range");

    // A finished pop always leaves a result behind.
    a_emit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> r_out_valid && r_out.byte_valid)
        else $error("pop produced no result");
`endif

endmodule

>>> rtl/scancode_to_ascii_key_fifo.sv
// Top level: set-1 scancode decoder feeding a character queue with read and flush.
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_ready    i_in_item  (t_in_item)
//   output   out        o_out_valid / i_out_ready  o_out_item (t_out_item)
//
// Key, flush and unused-op items are handled in the back end's idle state, so they sustain
// one item per cycle while the output is taken; the result passes through the command queue and the output register.
// A read alternates a load state and an emit state for each popped byte: the registered read
// port of the character store must be loaded before each byte is emitted.
// Reset is synchronous; the character store is not cleared and needs no clearing pass.
// A two-entry command queue lets the input keep accepting while a result waits.
module scancode_to_ascii_key_fifo #(
    parameter int unsigned FIFO_DEPTH = 256,
    parameter int unsigned MAX_READ   = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  s2a_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output s2a_pkg::t_out_item o_out_item
);
    import s2a_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // Item intake and classification.
    s2a_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_item   (i_in_item),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    // Command queue between the two halves.
    s2a_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd)
    );

    // Store, pointers and result generation.
    s2a_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (head_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

>>> bench/tb.sv
// Self-checking bench for the scancode decoder and its character queue.
`timescale 1ns / 1ps

module tb;
    import s2a_pkg::*;

    localparam int unsigned RING_DEPTH = 256;
    localparam int unsigned RP_W       = $clog2(RING_DEPTH);
    localparam int unsigned READ_CAP   = 64;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 40;
    localparam int unsigned FILL_ITEMS   = 257;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 150;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    // Typed-in expectation that travels with the item currently offered.
    logic       offer_typed;
    t_out_item  offer_result;

    // Bench copy of the decoder state.
    logic [7:0]      plain_map [128];
    logic [7:0]      shift_map [128];
    logic [7:0]      char_ring [RING_DEPTH];
    logic [RP_W-1:0] ring_head;
    logic [RP_W-1:0] ring_tail;
    logic            shift_down;

    t_out_item item_results [$];
    t_out_item outputs_due [$];
    int unsigned mismatches = 0;
    bit          hold_off_req = 1'b0;
    int unsigned burst_left;

    // One row of the directed stimulus; ch and kq are used only when typed.
    typedef struct {
        t_in_item   item;
        bit         typed;
        logic [7:0] ch;
        logic       kq;
    } t_row;

    localparam int unsigned DIR_ROWS = 26;
    t_row dir_table [DIR_ROWS] = '{
        '{'{OP_READ,  8'h00, 8'h00,           7'd10},  1'b1, 8'h00, 1'b0},
        '{'{OP_KEY,   8'h01, 8'h1E,           7'd0},   1'b1, 8'h61, 1'b1},
        '{'{OP_KEY,   8'h21, 8'h1E,           7'd0},   1'b1, 8'h00, 1'b0},
        '{'{OP_KEY,   8'h00, 8'h1E,           7'd0},   1'b1, 8'h00, 1'b0},
        '{'{OP_KEY,   8'hDF, 8'h10,           7'd127}, 1'b1, 8'h71, 1'b1},
        '{'{OP_KEY,   8'hFF, 8'h10,           7'd0},   1'b1, 8'h00, 1'b0},
        '{'{OP_KEY,   8'h01, SC_LSHIFT_MAKE,  7'd0},   1'b1, 8'h00, 1'b0},
        '{'{OP_KEY,   8'h01, 8'h35,           7'd0},   1'b1, 8'h3F, 1'b1},
        '{'{OP_KEY,   8'h01, SC_LSHIFT_BREAK, 7'd0},   1'b1, 8'h00, 1'b0},
        '{'{OP_KEY,   8'h01, SC_RSHIFT_MAKE,  7'd0},   1'b1, 8'h00, 1'b0},
        '{'{OP_KEY,   8'h01, 8'h02,           7'd0},   1'b1, 8'h21, 1'b1},
        '{'{OP_KEY,   8'h01, SC_RSHIFT_BREAK, 7'd0},   1'b1, 8'h00, 1'b0},
        '{'{OP_KEY,   8'h01, 8'h9E,           7'd0},   1'b1, 8'h00, 1'b0},
        '{'{OP_KEY,   8'h01, 8'h00,           7'd0},   1'b1, 8'h00, 1'b0},
        '{'{OP_KEY,   8'h01, 8'h7F,           7'd0},   1'b1, 8'h00, 1'b0},
        '{'{OP_KEY,   8'h01, 8'hFF,           7'd0},   1'b1, 8'h00, 1'b0},
        '{'{OP_KEY,   8'h01, 8'h4E,           7'd0},   1'b1, 8'h2B, 1'b1},
        '{'{OP_KEY,   8'h01, 8'h01,           7'd0},   1'b1, 8'h1B, 1'b1},
        '{'{OP_READ,  8'h00, 8'h00,           7'd0},   1'b1, 8'h00, 1'b0},
        '{'{OP_READ,  8'h00, 8'h00,           7'd2},   1'b0, 8'h00, 1'b0},
        '{'{OP_READ,  8'h00, 8'h00,           7'd127}, 1'b0, 8'h00, 1'b0},
        '{'{OP_READ,  8'h00, 8'h00,           7'd1},   1'b1, 8'h00, 1'b0},
        '{'{OP_KEY,   8'h01, 8'h39,           7'd0},   1'b1, 8'h20, 1'b1},
        '{'{OP_FLUSH, 8'h00, 8'h00,           7'd0},   1'b1, 8'h00, 1'b0},
        '{'{OP_READ,  8'h00, 8'h00,           7'd64},  1'b1, 8'h00, 1'b0},
        '{'{OP_SPARE, 8'hFF, 8'hFF,           7'd127}, 1'b1, 8'h00, 1'b0}
    };

    scancode_to_ascii_key_fifo #(
        .FIFO_DEPTH (RING_DEPTH),
        .MAX_READ   (READ_CAP)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Loads a run of consecutive scancodes into both layout maps.
    task automatic map_row(input int first, input string lower, input string upper);
        for (int k = 0; k < lower.len(); k++) begin
            plain_map[7'(first + k)] = lower[k];
            shift_map[7'(first + k)] = upper[k];
        end
    endtask

    // Builds the US layout; codes not listed translate to zero.
    task automatic build_layout();
        for (int k = 0; k < 128; k++) begin
            plain_map[7'(k)] = 8'h00;
            shift_map[7'(k)] = 8'h00;
        end
        map_row(2,  "1234567890-=", "!@#$%^&*()_+");
        map_row(16, "qwertyuiop[]", "QWERTYUIOP{}");
        map_row(30, "asdfghjkl;'",  "ASDFGHJKL:\"");
        map_row(43, "\\zxcvbnm,./", "|ZXCVBNM<>?");
        map_row(55, "*", "*");
        map_row(57, " ", " ");
        map_row(74, "-", "-");
        map_row(78, "+", "+");
        plain_map[1]  = 8'h1B;  shift_map[1]  = 8'h1B;
        plain_map[14] = 8'h08;  shift_map[14] = 8'h08;
        plain_map[15] = 8'h09;  shift_map[15] = 8'h09;
        plain_map[28] = 8'h0A;  shift_map[28] = 8'h0A;
        plain_map[41] = 8'h60;  shift_map[41] = 8'h7E;
    endtask

    function automatic logic [RP_W-1:0] ring_next(input logic [RP_W-1:0] p);
        return (p == RP_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Works out the results of one item and advances the bench state.
    task automatic decode_key_item(input t_in_item it);
        t_out_item   res;
        logic [7:0]  ch;
        int unsigned cap;
        int unsigned n;
        item_results.delete();
        res = '0;
        res.last_result = 1'b1;
        case (it.op)
            OP_KEY: begin
                ch = 8'h00;
                if (it.ctrl_status[STAT_OBF_BIT] && !it.ctrl_status[STAT_AUX_BIT]) begin
                    if (it.scan_byte == SC_LSHIFT_MAKE || it.scan_byte == SC_RSHIFT_MAKE) begin
                        shift_down = 1'b1;
                    end else if (it.scan_byte == SC_LSHIFT_BREAK ||
                                 it.scan_byte == SC_RSHIFT_BREAK) begin
                        shift_down = 1'b0;
                    end else if (!it.scan_byte[SC_BREAK_BIT]) begin
                        ch = shift_down ? shift_map[it.scan_byte[6:0]]
                                        : plain_map[it.scan_byte[6:0]];
                        // A full ring drops the character but still reports it.
                        if (ch != 8'h00 && ring_next(ring_head) != ring_tail) begin
                            char_ring[ring_head] = ch;
                            ring_head = ring_next(ring_head);
                            res.key_queued = 1'b1;
                        end
                    end
                end
                res.char_byte = ch;
                item_results.push_back(res);
            end
            OP_READ: begin
                cap = (32'(it.read_limit) > READ_CAP) ? READ_CAP : 32'(it.read_limit);
                n = 0;
                while (n < cap && ring_head != ring_tail) begin
                    res = '0;
                    res.char_byte = char_ring[ring_tail];
                    res.byte_valid = 1'b1;
                    res.bytes_popped = LIMIT_W'(n + 1);
                    ring_tail = ring_next(ring_tail);
                    item_results.push_back(res);
                    n++;
                end
                if (n == 0) begin
                    res = '0;
                    res.last_result = 1'b1;
                    item_results.push_back(res);
                end else begin
                    item_results[item_results.size() - 1].last_result = 1'b1;
                end
            end
            default: begin
                if (it.op == OP_FLUSH) begin
                    ring_head = '0;
                    ring_tail = '0;
                end
                item_results.push_back(res);
            end
        endcase
    endtask

    // Offers one item and returns at the edge where it is taken; gaps follow bursts.
    task automatic send(input t_in_item it, input bit typed = 1'b0,
                        input logic [7:0] ch = 8'h00, input logic kq = 1'b0);
        t_out_item tr;
        tr = '0;
        tr.char_byte = ch;
        tr.key_queued = kq;
        tr.last_result = 1'b1;
        i_in_valid   <= 1'b1;
        i_in_item    <= it;
        offer_typed  <= typed;
        offer_result <= tr;
        do @(posedge i_clk); while (!o_in_ready);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // A key item whose status passes the guard, with the other status bits random.
    function automatic t_in_item guarded_key(input logic [7:0] code);
        t_in_item it;
        it = t_in_item'($urandom);
        it.op = OP_KEY;
        it.ctrl_status[STAT_OBF_BIT] = 1'b1;
        it.ctrl_status[STAT_AUX_BIT] = 1'b0;
        it.scan_byte = code;
        return it;
    endfunction

    function automatic t_in_item read_item(input logic [6:0] lim);
        t_in_item it;
        it = t_in_item'($urandom);
        it.op = OP_READ;
        it.read_limit = lim;
        return it;
    endfunction

    // Stimulus: reset, directed table, random traffic, then a run that fills the ring.
    initial begin
        t_in_item    it;
        logic [7:0]  code;
        logic [7:0]  shift_code;
        int unsigned sent;
        int unsigned pick;
        int unsigned word_len;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_in_item    <= '0;
        offer_typed  <= 1'b0;
        offer_result <= '0;
        build_layout();
        shift_down = 1'b0;
        ring_head  = '0;
        ring_tail  = '0;
        burst_left = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send(dir_table[r].item, dir_table[r].typed, dir_table[r].ch, dir_table[r].kq);
        end

        hold_off_req = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // Typed word: makes and releases, sometimes under either shift key.
                word_len = $urandom_range(1, 6);
                shift_code = $urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_RSHIFT_MAKE;
                if ($urandom_range(0, 2) == 0) begin
                    send(guarded_key(shift_code));
                    sent++;
                end
                for (int k = 0; k < word_len; k++) begin
                    code = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 127))
                                                       : 8'($urandom_range(1, 57));
                    send(guarded_key(code));
                    sent++;
                    if ($urandom_range(0, 1)) begin
                        send(guarded_key(code | 8'h80));
                        sent++;
                    end
                end
                if ($urandom_range(0, 1)) begin
                    send(guarded_key(shift_code | 8'h80));
                    sent++;
                end
            end else if (pick < 80) begin
                send(read_item(($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                           : 7'($urandom_range(1, 8))));
                sent++;
            end else if (pick < 83) begin
                send(read_item(7'd0) ^ {OP_READ ^ OP_FLUSH, 23'd0});
                sent++;
            end else begin
                // Noise: every field random, the spare op included.
                it = t_in_item'($urandom);
                send(it);
                sent++;
            end
        end

        // Fill the ring past capacity, then drain it with reads at and above the cap.
        it = '0;
        it.op = OP_FLUSH;
        send(it);
        for (int k = 0; k < FILL_ITEMS; k++) begin
            send(guarded_key(($urandom_range(0, 1)) ? 8'($urandom_range(2, 13))
                                                    : 8'($urandom_range(16, 27))));
        end
        send(read_item(7'd64));
        for (int k = 0; k < 4; k++) send(read_item(7'd127));
        i_in_valid <= 1'b0;

        // Let the last accepted item register its expectations before waiting.
        @(posedge i_clk);
        wait (outputs_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outputs_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Each accepted item produces its expectations at the edge it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            decode_key_item(i_in_item);
            if (offer_typed) begin
                outputs_due.push_back(offer_result);
            end else begin
                foreach (item_results[k]) outputs_due.push_back(item_results[k]);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Each accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (outputs_due.size() == 0) begin
                $error("result with nothing expected: %0h", o_out_item);
                mismatches++;
            end else begin
                want = outputs_due.pop_front();
                check_field("char_byte",    want.char_byte,    o_out_item.char_byte);
                check_field("key_queued",   want.key_queued,   o_out_item.key_queued);
                check_field("byte_valid",   want.byte_valid,   o_out_item.byte_valid);
                check_field("bytes_popped", want.bytes_popped, o_out_item.bytes_popped);
                check_field("last_result",  want.last_result,  o_out_item.last_result);
            end
        end
    end

    // Receiver: ready follows a randomly picked mode, with one long hold-off.
    initial begin
        int unsigned cyc;
        int unsigned mode;
        int unsigned hold_left;
        bit          held;
        logic [15:0] stall_pat;
        held         = 1'b0;
        hold_left    = 0;
        cyc          = 0;
        mode         = 0;
        stall_pat    = 16'hFFFF;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 50 == 0) begin
                mode = $urandom_range(0, 2);
                stall_pat = 16'($urandom);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_off_req && !held) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= ($urandom_range(0, 3) != 0);
                    default: i_out_ready <= stall_pat[4'(cyc)];
                endcase
            end
        end
    end

    // Watchdog for a hung run.
    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

endmodule
